/* rtl/mfs_pkg.sv */
// Shared types, register map, result codes and reset values for the
// multirate frame scheduler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfs_pkg;

    localparam int NUM_CFG    = 7;
    localparam int CFG_W      = 16;
    localparam int FRAME_W    = 16;
    localparam int UPTIME_W   = 32;
    localparam int NUM_RATES  = 6;
    localparam int KIND_W     = 4;
    localparam int NUM_KINDS  = 10;
    localparam int NUM_SUMS   = 9;
    localparam int MAX_AXES   = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int OUT_SUM_W  = 32;
    localparam int OUT_BITS   = OUT_SUM_W + NUM_RATES + 1 + 2 + FRAME_W + UPTIME_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_SUM_WIDTH    = 32;
    localparam int DEF_AXES         = 3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FRAME_LENGTH = 3'd0;
    localparam logic [2:0] REG_FAST_DIV     = 3'd1;
    localparam logic [2:0] REG_SLOW_DIV     = 3'd2;
    localparam logic [2:0] REG_RATE3_DIV    = 3'd3;
    localparam logic [2:0] REG_RATE4_DIV    = 3'd4;
    localparam logic [2:0] REG_RATE5_DIV    = 3'd5;
    localparam logic [2:0] REG_RATE6_DIV    = 3'd6;

    // strobe bit positions
    localparam int RATE_FAST = 0;
    localparam int RATE_SLOW = 1;
    localparam int RATE_MAG  = 3;

    localparam logic [KIND_W-1:0] KIND_STATUS = 4'd0;

    localparam logic [1:0] BARO_NONE = 2'd0;
    localparam logic [1:0] BARO_TEMP = 2'd1;
    localparam logic [1:0] BARO_PRES = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = 16'd1000;
    localparam logic [NUM_RATES-1:0][CFG_W-1:0] DIV_RESET =
        {16'd1000, 16'd200, 16'd100, 16'd20, 16'd10, 16'd2};

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef struct packed {
        cfg_word_t                     frame_length;
        logic [NUM_RATES-1:0][CFG_W-1:0] div;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic wrap;
    } tick_ctl_t;

    typedef struct packed {
        logic [NUM_RATES-1:0] strobes;
        logic                 mag;
    } rate_evt_t;

    typedef struct packed {
        logic [NUM_RATES-1:0] strobes;
        logic                 mag;
        logic [1:0]           baro;
        logic [FRAME_W-1:0]   frame;
        logic [UPTIME_W-1:0]  uptime;
        logic                 fast_dump;
        logic                 slow_dump;
    } snap_t;

endpackage

`default_nettype wire

/* rtl/multirate_frame_scheduler_unit.sv */
// Top level of the multirate frame scheduler: register file, phase counters,
// tick core and result serializer. Depends on mfs_pkg and the mfs_* modules.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata: tick request (run, samples)
//   m_*      out  tvalid/tready      tdata/tuser/tlast: result requests
//   apb      in   psel/penable       7 x 16-bit registers at 4*i
//
// One tick is accepted per cycle while the result side keeps up; it yields
// 1, 1+2*AXES, 1+AXES or 1+3*AXES result requests, sent one per cycle
// while m_tready is high, so the result port sets the sustained rate. After
// every register write, s_tready stays low while the bit-serial remainder
// unit realigns the rate phases to the current frame. Reset is asynchronous.
`timescale 1ns / 1ps
`default_nettype none

module multirate_frame_scheduler_unit #(
    parameter  int SAMPLE_WIDTH = mfs_pkg::DEF_SAMPLE_WIDTH,
    parameter  int SUM_WIDTH    = mfs_pkg::DEF_SUM_WIDTH,
    parameter  int AXES         = mfs_pkg::DEF_AXES,
    localparam int IN_W         = ((2 + 6 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // run_enable, temperature_taken, accel_x, accel_y, accel_z,
    // gyro_roll, gyro_pitch, gyro_yaw, zero pad
    input  logic [IN_W-1:0]                 s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sum_value, rate_strobes, mag_request, baro_action, frame_value,
    // uptime_ms, zero pad
    output logic [mfs_pkg::OUT_W-1:0]       m_tdata,
    // result_kind
    output logic [mfs_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mfs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mfs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mfs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import mfs_pkg::*;

    cfg_t                               cfg;
    logic                               cfg_wr;
    tick_ctl_t                          tick;
    rate_evt_t                          evt;
    logic                               resync_busy;
    logic [FRAME_W-1:0]                 frame;
    logic                               pend_valid;
    logic                               pend_take;
    snap_t                              snap;
    logic [NUM_SUMS-1:0][SUM_WIDTH-1:0] sums;

    mfs_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    mfs_phase_ctr u_phase (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_wr (cfg_wr),
        .frame  (frame),
        .tick   (tick),
        .evt    (evt),
        .busy   (resync_busy)
    );

    mfs_tick_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH),
        .AXES         (AXES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg         (cfg),
        .resync_busy (resync_busy),
        .evt         (evt),
        .tick        (tick),
        .frame       (frame),
        .pend_valid  (pend_valid),
        .snap        (snap),
        .sums        (sums),
        .pend_take   (pend_take)
    );

    mfs_result_ser #(
        .SUM_WIDTH (SUM_WIDTH),
        .AXES      (AXES)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .snap       (snap),
        .sums       (sums),
        .pend_take  (pend_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/mfs_cfg_regs.sv */
// APB register file for frame length and the six rate divisors.
// Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mfs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mfs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mfs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output mfs_pkg::cfg_t                   cfg,
    output logic                            cfg_wr
);
    import mfs_pkg::*;

    logic                            wr_en;
    logic [2:0]                      idx;
    logic [CFG_W-1:0]                frame_length_reg;
    logic [NUM_RATES-1:0][CFG_W-1:0] div_reg;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg_wr = wr_en && (idx < 3'(NUM_CFG));

    assign cfg.frame_length = frame_length_reg;
    assign cfg.div          = div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RESET;
            div_reg          <= DIV_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[CFG_W-1:0];
                REG_FAST_DIV:     div_reg[0]       <= pwdata[CFG_W-1:0];
                REG_SLOW_DIV:     div_reg[1]       <= pwdata[CFG_W-1:0];
                REG_RATE3_DIV:    div_reg[2]       <= pwdata[CFG_W-1:0];
                REG_RATE4_DIV:    div_reg[3]       <= pwdata[CFG_W-1:0];
                REG_RATE5_DIV:    div_reg[4]       <= pwdata[CFG_W-1:0];
                REG_RATE6_DIV:    div_reg[5]       <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_FRAME_LENGTH: prdata = APB_DATA_W'(frame_length_reg);
            REG_FAST_DIV:     prdata = APB_DATA_W'(div_reg[0]);
            REG_SLOW_DIV:     prdata = APB_DATA_W'(div_reg[1]);
            REG_RATE3_DIV:    prdata = APB_DATA_W'(div_reg[2]);
            REG_RATE4_DIV:    prdata = APB_DATA_W'(div_reg[3]);
            REG_RATE5_DIV:    prdata = APB_DATA_W'(div_reg[4]);
            REG_RATE6_DIV:    prdata = APB_DATA_W'(div_reg[5]);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/mfs_phase_ctr.sv */
// Per-rate phase counters (frame mod divisor) with a bit-serial remainder
// resync after each register write. Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_phase_ctr (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mfs_pkg::cfg_t                cfg,
    input  logic                         cfg_wr,
    input  logic [mfs_pkg::FRAME_W-1:0]  frame,
    input  mfs_pkg::tick_ctl_t           tick,
    output mfs_pkg::rate_evt_t           evt,
    output logic                         busy
);
    import mfs_pkg::*;

    localparam int BIT_W = $clog2(FRAME_W);

    logic [NUM_RATES-1:0][CFG_W-1:0] phase_reg;
    logic [NUM_RATES-1:0][CFG_W-1:0] phase_next;
    logic [NUM_RATES-1:0][CFG_W-1:0] rem_reg;
    logic [NUM_RATES-1:0][CFG_W-1:0] rem_next;
    logic                            busy_reg;
    logic [BIT_W-1:0]                bit_reg;

    assign busy = busy_reg;

    // advance one frame, or restart at frame one; also the next remainder step and the rate events
    always_comb
    begin
        logic [CFG_W:0] inc;
        logic [CFG_W:0] shifted;
        logic [CFG_W:0] diff;
        for (int r = 0; r < NUM_RATES; r++)
        begin
            inc = {1'b0, phase_reg[r]} + (CFG_W+1)'(1);
            if (tick.wrap)
                phase_next[r] = (cfg.div[r] == CFG_W'(1)) ? '0 : CFG_W'(1);
            else if (inc == {1'b0, cfg.div[r]})
                phase_next[r] = '0;
            else
                phase_next[r] = inc[CFG_W-1:0];

            shifted = {rem_reg[r], frame[bit_reg]};
            diff    = shifted - {1'b0, cfg.div[r]};
            if (shifted >= {1'b0, cfg.div[r]})
                rem_next[r] = diff[CFG_W-1:0];
            else
                rem_next[r] = shifted[CFG_W-1:0];

            evt.strobes[r] = tick.advance && (cfg.div[r] != '0) && (phase_next[r] == '0);
        end
        evt.mag = tick.advance && (cfg.div[RATE_MAG] != '0)
                  && (phase_next[RATE_MAG] == cfg.div[RATE_MAG] - CFG_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            bit_reg   <= '0;
            phase_reg <= '0;
            rem_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            busy_reg <= 1'b1;
            bit_reg  <= BIT_W'(FRAME_W - 1);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            if (bit_reg == '0)
            begin
                busy_reg  <= 1'b0;
                phase_reg <= rem_next;
            end
            else
            begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
        else if (tick.advance)
        begin
            phase_reg <= phase_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) tick.advance |-> !busy_reg)
        else $error("frame advanced during phase resync");

    for (genvar g = 0; g < NUM_RATES; g++)
    begin : g_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            $fell(busy_reg) && (cfg.div[g] != '0) |-> phase_reg[g] < cfg.div[g])
            else $error("resynced phase out of range");
    end

endmodule

`default_nettype wire

/* rtl/mfs_tick_core.sv */
// Tick state update: frame, uptime, accumulators, barometer flag, and the
// pending result snapshot. Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_tick_core #(
    parameter  int SAMPLE_WIDTH = mfs_pkg::DEF_SAMPLE_WIDTH,
    parameter  int SUM_WIDTH    = mfs_pkg::DEF_SUM_WIDTH,
    parameter  int AXES         = mfs_pkg::DEF_AXES,
    localparam int IN_W         = ((2 + 6 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [IN_W-1:0]                               s_tdata,
    input  mfs_pkg::cfg_t                                 cfg,
    input  logic                                          resync_busy,
    input  mfs_pkg::rate_evt_t                            evt,
    output mfs_pkg::tick_ctl_t                            tick,
    output logic [mfs_pkg::FRAME_W-1:0]                   frame,
    output logic                                          pend_valid,
    output mfs_pkg::snap_t                                snap,
    output logic [mfs_pkg::NUM_SUMS-1:0][SUM_WIDTH-1:0]   sums,
    input  logic                                          pend_take
);
    import mfs_pkg::*;

    logic                                 accept;
    logic                                 run;
    logic                                 taken;
    logic [FRAME_W:0]                     frame_inc;
    logic                                 wrap;
    logic [FRAME_W-1:0]                   frame_new;
    logic                                 temp_clr;
    logic                                 fast_dump;
    logic                                 slow_dump;
    logic [1:0]                           baro;
    logic [UPTIME_W-1:0]                  uptime_new;
    logic [MAX_AXES-1:0][SUM_WIDTH-1:0]   fa_add;
    logic [MAX_AXES-1:0][SUM_WIDTH-1:0]   fg_add;
    logic [MAX_AXES-1:0][SUM_WIDTH-1:0]   sa_add;

    logic [FRAME_W-1:0]                   frame_reg;
    logic [UPTIME_W-1:0]                  uptime_reg;
    logic                                 temp_reg;
    logic [MAX_AXES-1:0][SUM_WIDTH-1:0]   fast_acc_reg;
    logic [MAX_AXES-1:0][SUM_WIDTH-1:0]   fast_gyro_reg;
    logic [MAX_AXES-1:0][SUM_WIDTH-1:0]   slow_acc_reg;
    logic                                 pend_valid_reg;
    snap_t                                snap_reg;
    logic [NUM_SUMS-1:0][SUM_WIDTH-1:0]   sums_reg;

    assign run        = s_tdata[0];
    assign taken      = s_tdata[1];
    assign s_tready   = !resync_busy && (!pend_valid_reg || pend_take);
    assign accept     = s_tvalid && s_tready;

    assign frame_inc  = {1'b0, frame_reg} + (FRAME_W+1)'(1);
    assign wrap       = frame_inc > {1'b0, cfg.frame_length};
    assign frame_new  = wrap ? FRAME_W'(1) : frame_inc[FRAME_W-1:0];
    assign uptime_new = uptime_reg + UPTIME_W'(1);

    assign tick.advance = accept && run;
    assign tick.wrap    = wrap;
    assign frame        = frame_reg;

    assign temp_clr  = taken ? 1'b0 : temp_reg;
    assign fast_dump = evt.strobes[RATE_FAST];
    assign slow_dump = evt.strobes[RATE_SLOW];
    assign baro      = slow_dump ? (temp_clr ? BARO_PRES : BARO_TEMP) : BARO_NONE;

    always_comb
    begin
        logic [SAMPLE_WIDTH-1:0]           acc_s;
        logic [SAMPLE_WIDTH-1:0]           gyr_s;
        logic [SUM_WIDTH+SAMPLE_WIDTH-1:0] acc_w;
        logic [SUM_WIDTH+SAMPLE_WIDTH-1:0] gyr_w;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            acc_s = s_tdata[2 + a * SAMPLE_WIDTH +: SAMPLE_WIDTH];
            gyr_s = s_tdata[2 + (a + MAX_AXES) * SAMPLE_WIDTH +: SAMPLE_WIDTH];
            acc_w = {{SUM_WIDTH{acc_s[SAMPLE_WIDTH-1]}}, acc_s};
            gyr_w = {{SUM_WIDTH{gyr_s[SAMPLE_WIDTH-1]}}, gyr_s};
            if (a >= AXES)
            begin
                acc_w = '0;
                gyr_w = '0;
            end
            fa_add[a] = fast_acc_reg[a]  + acc_w[SUM_WIDTH-1:0];
            fg_add[a] = fast_gyro_reg[a] + gyr_w[SUM_WIDTH-1:0];
            sa_add[a] = slow_acc_reg[a]  + acc_w[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg      <= '0;
            uptime_reg     <= '0;
            temp_reg       <= 1'b0;
            fast_acc_reg   <= '0;
            fast_gyro_reg  <= '0;
            slow_acc_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                uptime_reg     <= uptime_new;
                temp_reg       <= slow_dump ? 1'b1 : temp_clr;
                pend_valid_reg <= 1'b1;
                if (run)
                begin
                    frame_reg     <= frame_new;
                    fast_acc_reg  <= fast_dump ? '0 : fa_add;
                    fast_gyro_reg <= fast_dump ? '0 : fg_add;
                    slow_acc_reg  <= slow_dump ? '0 : sa_add;
                end
            end
            else if (pend_take)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snap_reg.strobes   <= evt.strobes;
            snap_reg.mag       <= evt.mag;
            snap_reg.baro      <= baro;
            snap_reg.frame     <= run ? frame_new : frame_reg;
            snap_reg.uptime    <= uptime_new;
            snap_reg.fast_dump <= fast_dump;
            snap_reg.slow_dump <= slow_dump;
            for (int a = 0; a < MAX_AXES; a++)
            begin
                sums_reg[a]                <= fa_add[a];
                sums_reg[MAX_AXES + a]     <= fg_add[a];
                sums_reg[2 * MAX_AXES + a] <= sa_add[a];
            end
        end
    end

    assign pend_valid = pend_valid_reg;
    assign snap       = snap_reg;
    assign sums       = sums_reg;

    assert property (@(posedge clk) disable iff (!rst_n) pend_take |-> pend_valid_reg)
        else $error("snapshot taken while none pending");

    assert property (@(posedge clk) disable iff (!rst_n) accept && run |=> frame_reg != '0)
        else $error("running tick left frame at zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && run && evt.strobes[RATE_SLOW] |=> temp_reg)
        else $error("slow strobe did not leave temperature pending");

endmodule

`default_nettype wire

/* rtl/mfs_result_ser.sv */
// Result buffer that sends the status item and the dumped sums of one tick,
// one request per cycle while m_tready is high. Depends on mfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfs_result_ser #(
    parameter int SUM_WIDTH = mfs_pkg::DEF_SUM_WIDTH,
    parameter int AXES      = mfs_pkg::DEF_AXES
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          pend_valid,
    input  mfs_pkg::snap_t                                snap,
    input  logic [mfs_pkg::NUM_SUMS-1:0][SUM_WIDTH-1:0]   sums,
    output logic                                          pend_take,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [mfs_pkg::OUT_W-1:0]                     m_tdata,
    output logic [mfs_pkg::KIND_W-1:0]                    m_tuser,
    output logic                                          m_tlast
);
    import mfs_pkg::*;

    localparam logic [MAX_AXES-1:0] AXIS_MASK = MAX_AXES'((1 << AXES) - 1);

    logic [NUM_KINDS-1:0]               mask_reg;
    snap_t                              snap_reg;
    logic [NUM_SUMS-1:0][SUM_WIDTH-1:0] sums_reg;

    logic [NUM_KINDS-1:0]               load_mask;
    logic [NUM_KINDS-1:0]               mask_rest;
    logic [KIND_W-1:0]                  kind;
    logic                               out_last;
    logic                               hs;
    logic                               ser_free;
    logic [SUM_WIDTH-1:0]               sel_sum;
    logic [SUM_WIDTH+OUT_SUM_W-1:0]     sel_ext;
    logic [KIND_W-1:0]                  sum_idx;

    assign mask_rest = mask_reg & (mask_reg - NUM_KINDS'(1));
    assign out_last  = (mask_rest == '0);
    assign m_tvalid  = (mask_reg != '0);
    assign hs        = m_tvalid && m_tready;
    assign ser_free  = !m_tvalid || (hs && out_last);
    assign pend_take = pend_valid && ser_free;

    assign load_mask = {snap.slow_dump ? AXIS_MASK : MAX_AXES'(0),
                        snap.fast_dump ? AXIS_MASK : MAX_AXES'(0),
                        snap.fast_dump ? AXIS_MASK : MAX_AXES'(0),
                        1'b1};

    always_comb
    begin
        logic found;
        found = 1'b0;
        kind  = KIND_STATUS;
        for (int i = 0; i < NUM_KINDS; i++)
        begin
            if (!found && mask_reg[i])
            begin
                kind  = KIND_W'(i);
                found = 1'b1;
            end
        end
    end

    assign sum_idx = kind - KIND_W'(1);
    assign sel_sum = (kind == KIND_STATUS) ? '0 : sums_reg[sum_idx];
    assign sel_ext = {{OUT_SUM_W{1'b0}}, sel_sum};

    assign m_tuser = kind;
    assign m_tlast = out_last;
    assign m_tdata = {(OUT_W - OUT_BITS)'(0), snap_reg.uptime, snap_reg.frame, snap_reg.baro,
                      snap_reg.mag, snap_reg.strobes, sel_ext[OUT_SUM_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (pend_take)
        begin
            mask_reg <= load_mask;
        end
        else if (hs)
        begin
            mask_reg <= mask_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_take)
        begin
            snap_reg <= snap;
            sums_reg <= sums;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_take |=> m_tvalid && (m_tuser == KIND_STATUS))
        else $error("tick results do not open with status");

    assert property (@(posedge clk) disable iff (!rst_n)
        hs && m_tlast && !pend_take |=> !m_tvalid)
        else $error("results continue past last");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_STATUS) && !snap_reg.fast_dump && !snap_reg.slow_dump
        |-> m_tlast)
        else $error("status without dumps not marked last");

endmodule

`default_nettype wire
